@@ sv/ime_pkg.sv @@
// ime_pkg: shared types and constants of the image mirror engine.
// Word structs for the item and result channels, register indexes, function codes.
// No dependencies.
`timescale 1ns / 1ps

package ime_pkg;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;
  localparam int OUT_PIX_BITS  = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_FLIP_HORIZONTAL = 2'd2,
    REG_UNUSED          = 2'd3
  } cfg_index_t;

  typedef enum logic {
    FUNC_STORE = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic                     RST_FLIP_HORIZ   = 1'b1;

  typedef struct packed {
    func_t                   func;
    logic [OUT_PIX_BITS-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [OUT_PIX_BITS-1:0] pixel_out;
    logic                    last_of_frame;
  } out_word_t;

endpackage

@@ sv/ime_ram.sv @@
// ime_ram: generic single-clock RAM, one write port, one read port.
// Read data is registered and holds while rd_en is low.
// No dependencies.
`timescale 1ns / 1ps

module ime_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/image_mirror_engine_top.sv @@
// image_mirror_engine_top: frame store with mirrored raster readout.
// Store word: written into the frame RAM at the accept edge.
// Fetch word: address multiply (S_ADDR), RAM read (S_READ) and output register (S_HOLD,
// which waits while an earlier result is not taken); no new word is accepted until it ends.
// Reset (synchronous, rst_n low): counters zero, size registers 256x256, horizontal
// flip; frame RAM contents are not cleared. Depends on ime_pkg and ime_ram.
`timescale 1ns / 1ps

module image_mirror_engine_top
  import ime_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_word_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_word_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TB    = $clog2(DEPTH + 1);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int RB    = $clog2(MAX_HEIGHT);
  localparam int SW    = (PIXEL_BITS < OUT_PIX_BITS) ? PIXEL_BITS : OUT_PIX_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_READ = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CFG_DATA_BITS-1:0] width_r, height_r;
  logic                     flip_h_r;
  logic [AW-1:0]            store_pos_r, store_pos_nxt;
  logic [RB-1:0]            row_r, row_nxt;
  logic [CB-1:0]            col_r, col_nxt;
  logic [RB-1:0]            rm_r, rm_nxt;
  logic [CB-1:0]            cm_r, cm_nxt;
  logic                     last_r, last_nxt;
  logic [AW-1:0]            addr_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [SW-1:0]            out_pix_r;
  logic                     out_last_r;

  logic [WB-1:0]    w_eff;
  logic [HB-1:0]    h_eff;
  logic [TB-1:0]    total;
  logic [AW-1:0]    pos_cur;
  logic [TB-1:0]    pos_inc;
  logic [RB-1:0]    row_cur;
  logic [CB-1:0]    col_cur;
  logic [RB+WB-1:0] row_base;
  logic             in_acc, store_acc, fetch_acc, out_load;
  logic [SW-1:0]    rd_data;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WB'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HB'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = HB'(MAX_HEIGHT);
    end else begin
      h_eff = HB'(height_r);
    end
  end

  assign total = TB'(w_eff) * TB'(h_eff);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign store_acc = in_acc && (in_data.func == FUNC_STORE);
  assign fetch_acc = in_acc && (in_data.func == FUNC_FETCH);
  assign out_load  = (state_r == S_HOLD) && (!out_valid_r || out_ready);

  // store pointer
  always_comb begin
    pos_cur = (TB'(store_pos_r) >= total) ? '0 : store_pos_r;
    pos_inc = TB'(pos_cur) + TB'(1);
    store_pos_nxt = store_pos_r;
    if (store_acc) begin
      store_pos_nxt = (pos_inc >= total) ? '0 : AW'(pos_inc);
    end
  end

  // fetch counters and mirrored coordinates
  always_comb begin
    row_cur = row_r;
    col_cur = col_r;
    if ((HB'(row_r) >= h_eff) || (WB'(col_r) >= w_eff)) begin
      row_cur = '0;
      col_cur = '0;
    end
    last_nxt = (HB'(row_cur) == h_eff - HB'(1)) && (WB'(col_cur) == w_eff - WB'(1));
    rm_nxt   = row_cur;
    cm_nxt   = col_cur;
    if (flip_h_r) begin
      cm_nxt = CB'(w_eff - WB'(1) - WB'(col_cur));
    end else begin
      rm_nxt = RB'(h_eff - HB'(1) - HB'(row_cur));
    end
    row_nxt = row_r;
    col_nxt = col_r;
    if (fetch_acc) begin
      if (last_nxt) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (WB'(col_cur) == w_eff - WB'(1)) begin
        row_nxt = row_cur + RB'(1);
        col_nxt = '0;
      end else begin
        row_nxt = row_cur;
        col_nxt = col_cur + CB'(1);
      end
    end
  end

  assign row_base = (RB+WB)'(rm_r) * (RB+WB)'(w_eff);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (fetch_acc) state_nxt = S_ADDR;
      end
      S_ADDR: state_nxt = S_READ;
      S_READ: state_nxt = S_HOLD;
      S_HOLD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      store_pos_r <= '0;
      row_r       <= '0;
      col_r       <= '0;
      width_r     <= RST_FRAME_WIDTH;
      height_r    <= RST_FRAME_HEIGHT;
      flip_h_r    <= RST_FLIP_HORIZ;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      store_pos_r <= store_pos_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:     width_r  <= cfg_data;
          REG_FRAME_HEIGHT:    height_r <= cfg_data;
          REG_FLIP_HORIZONTAL: flip_h_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      rm_r   <= rm_nxt;
      cm_r   <= cm_nxt;
      last_r <= last_nxt;
    end
    if (state_r == S_ADDR) begin
      addr_r <= AW'(row_base + (RB+WB)'(cm_r));
    end
    if (out_load) begin
      out_pix_r  <= rd_data;
      out_last_r <= last_r;
    end
  end

  ime_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (store_acc),
    .wr_addr (pos_cur),
    .wr_data (SW'(in_data.pixel_in)),
    .rd_en   (state_r == S_READ),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign out_valid              = out_valid_r;
  assign out_data.pixel_out     = OUT_PIX_BITS'(out_pix_r);
  assign out_data.last_of_frame = out_last_r;

endmodule

@@ sv/ime_checker.sv @@
// ime_checker: port-level assertions for image_mirror_engine_top, with its bind.
// Watches the item, result and config channels only. Depends on ime_pkg.
`timescale 1ns / 1ps

module ime_checker
  import ime_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input in_word_t                 in_data,
  input logic                     out_valid,
  input logic                     out_ready,
  input out_word_t                out_data,
  input logic                     cfg_valid,
  input logic                     cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == FUNC_STORE) && !out_valid |=> !out_valid)
    else $error("store word produced a result");

  a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == FUNC_FETCH) |=> !in_ready)
    else $error("fetch word did not hold off the input");

  a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind image_mirror_engine_top ime_checker u_ime_checker (.*);
